// ----- design/nrl_pkg.sv -----
// shared types, constants and digit pattern functions for the label unit
package nrl_pkg;

  // label styles
  localparam logic [1:0] STYLE_ALPHA_LOWER = 2'd0;
  localparam logic [1:0] STYLE_ALPHA_UPPER = 2'd1;
  localparam logic [1:0] STYLE_ROMAN_LOWER = 2'd2;
  localparam logic [1:0] STYLE_ROMAN_UPPER = 2'd3;

  localparam int FIELD_W = 16;
  localparam logic [15:0] ROMAN_MAX = 16'd3999;

  // reciprocal constants, quotient = (n * RECIP) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 20;
  localparam logic [16:0] RECIP_ALPHA = 17'd40330;  // ceil(2^20 / 26)
  localparam logic [16:0] RECIP_DEC = 17'd104858;   // ceil(2^20 / 10)

  // roman mark codes within a digit group
  localparam logic [1:0] MARK_ONE = 2'd0;
  localparam logic [1:0] MARK_FIVE = 2'd1;
  localparam logic [1:0] MARK_TEN = 2'd2;

  // roman group indexes, most significant first
  localparam logic [1:0] GRP_THOUSANDS = 2'd0;
  localparam logic [1:0] GRP_HUNDREDS = 2'd1;
  localparam logic [1:0] GRP_TENS = 2'd2;
  localparam logic [1:0] GRP_UNITS = 2'd3;

  // ascii characters
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_I = 7'h69;
  localparam logic [6:0] CH_V = 7'h76;
  localparam logic [6:0] CH_X = 7'h78;
  localparam logic [6:0] CH_L = 7'h6C;
  localparam logic [6:0] CH_C = 7'h63;
  localparam logic [6:0] CH_D = 7'h64;
  localparam logic [6:0] CH_M = 7'h6D;
  localparam logic [6:0] CH_NUL = 7'h00;
  localparam logic [6:0] CASE_OFFSET = 7'd32;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
    logic       error;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_EMIT,
    ST_ERR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic advance;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_err;
    logic done;
    logic empty;
    logic last;
  } dp_status_t;

  // number of marks a roman digit takes
  function automatic logic [2:0] pat_len(input logic [4:0] d);
    logic [2:0] len;
    case (d)
      5'd0: len = 3'd0;
      5'd1: len = 3'd1;
      5'd2: len = 3'd2;
      5'd3: len = 3'd3;
      5'd4: len = 3'd2;
      5'd5: len = 3'd1;
      5'd6: len = 3'd2;
      5'd7: len = 3'd3;
      5'd8: len = 3'd4;
      5'd9: len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // mark at position j of a roman digit
  function automatic logic [1:0] pat_mark(input logic [4:0] d, input logic [1:0] j);
    logic [1:0] m;
    case (d)
      5'd4: m = (j == 2'd0) ? MARK_ONE : MARK_FIVE;
      5'd5: m = MARK_FIVE;
      5'd6, 5'd7, 5'd8: m = (j == 2'd0) ? MARK_FIVE : MARK_ONE;
      5'd9: m = (j == 2'd0) ? MARK_ONE : MARK_TEN;
      default: m = MARK_ONE;
    endcase
    return m;
  endfunction

  // lower case letter for a mark of a group
  function automatic logic [6:0] roman_char(input logic [1:0] g, input logic [1:0] m);
    logic [6:0] ch;
    case (g)
      GRP_THOUSANDS: ch = CH_M;
      GRP_HUNDREDS: ch = (m == MARK_ONE) ? CH_C : ((m == MARK_FIVE) ? CH_D : CH_M);
      GRP_TENS: ch = (m == MARK_ONE) ? CH_X : ((m == MARK_FIVE) ? CH_L : CH_C);
      GRP_UNITS: ch = (m == MARK_ONE) ? CH_I : ((m == MARK_FIVE) ? CH_V : CH_X);
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// ----- design/nrl_ctrl.sv -----
// controller state machine for the label unit
module nrl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  nrl_pkg::dp_status_t status,
  output nrl_pkg::dp_cmd_t    cmd
);
  import nrl_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = status.is_err ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        state_next = ST_REM;
      end
      ST_REM: begin
        cmd.rem = 1'b1;
        state_next = status.done ? ST_EMIT : ST_DIV;
      end
      ST_EMIT: begin
        out_valid = !status.empty;
        // empty roman groups are stepped over without a transfer
        if (status.empty) begin
          cmd.advance = 1'b1;
        end else if (!out_stall) begin
          cmd.advance = 1'b1;
          if (status.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/nrl_datapath.sv -----
// digit extraction by reciprocal multiply and character generation
module nrl_datapath #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                clk,
  input  nrl_pkg::in_t        in_data,
  input  nrl_pkg::dp_cmd_t    cmd,
  output nrl_pkg::dp_status_t status,
  output nrl_pkg::out_t       out_data
);
  import nrl_pkg::*;

  localparam int EFF_W = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam logic [FIELD_W-1:0] VMASK = FIELD_W'((33'd1 << EFF_W) - 33'd1);

  logic              roman;
  logic              upper;
  logic              err;
  logic [15:0]       n;
  logic [15:0]       q;
  logic [1:0]        ndig;
  logic [1:0]        g;
  logic [1:0]        j;
  logic [4:0]        digits [4];

  logic [15:0]       val;
  logic              in_roman;
  logic [32:0]       prod;
  logic [15:0]       qd;
  logic [15:0]       rem_full;
  logic [4:0]        d;
  logic [2:0]        len;
  logic              grp_end;
  logic              later_empty;
  logic [6:0]        lower_ch;
  logic [6:0]        ch;
  logic              last;

  // input value after width mask, error check
  assign val = in_data.value & VMASK;
  assign in_roman = in_data.command[1];
  assign status.is_err = (val == '0) || (in_roman && (val > ROMAN_MAX));

  // quotient by reciprocal, remainder by shift-add of the registered quotient
  assign prod = {17'd0, n} * {16'd0, (roman ? RECIP_DEC : RECIP_ALPHA)};
  assign qd = roman ? ((q << 3) + (q << 1)) : ((q << 4) + (q << 3) + (q << 1));
  assign rem_full = n - qd;
  assign status.done = roman ? (ndig == 2'd2) : (q == '0);

  // current digit and roman group shape
  assign d = digits[g];
  assign len = pat_len(d);
  assign grp_end = ({1'b0, j} == (len - 3'd1));
  always_comb begin
    case (g)
      GRP_THOUSANDS: later_empty = (digits[1] == '0) && (digits[2] == '0) && (digits[3] == '0);
      GRP_HUNDREDS: later_empty = (digits[2] == '0) && (digits[3] == '0);
      GRP_TENS: later_empty = (digits[3] == '0);
      default: later_empty = 1'b1;
    endcase
  end
  assign status.empty = roman && (len == 3'd0);

  // character and last mark
  assign lower_ch = roman ? roman_char(g, pat_mark(d, j)) : (CH_LOWER_A + {2'd0, d});
  assign ch = upper ? (lower_ch - CASE_OFFSET) : lower_ch;
  assign last = roman ? (grp_end && later_empty) : (g == 2'd0);
  assign status.last = last;

  // result payload
  always_comb begin
    if (err) begin
      out_data.character = CH_NUL;
      out_data.last = 1'b1;
      out_data.error = 1'b1;
    end else begin
      out_data.character = ch;
      out_data.last = last;
      out_data.error = 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      roman <= in_roman;
      upper <= in_data.command[0];
      err <= status.is_err;
      n <= in_roman ? val : (val - 16'd1);
      ndig <= '0;
      g <= GRP_THOUSANDS;
      j <= '0;
    end
    if (cmd.div) begin
      q <= {3'd0, prod[32:RECIP_SHIFT]};
    end
    if (cmd.rem) begin
      ndig <= ndig + 2'd1;
      if (roman) begin
        digits[2'd3 - ndig] <= rem_full[4:0];
        n <= q;
        if (ndig == 2'd2) begin
          digits[0] <= q[4:0];
        end
      end else begin
        digits[ndig] <= rem_full[4:0];
        n <= q - 16'd1;
        g <= ndig;
      end
    end
    if (cmd.advance) begin
      if (!roman) begin
        g <= g - 2'd1;
      end else if (status.empty || grp_end) begin
        g <= g + 2'd1;
        j <= '0;
      end else begin
        j <= j + 2'd1;
      end
    end
  end

endmodule

// ----- design/number_to_roman_or_alpha_label_unit.sv -----
// number to roman or alpha label unit, one ascii character per output transfer
// alpha: a divide and remainder step per letter, then one letter per transfer
// roman: divide and remainder steps per decimal digit, then the marks, empty groups skipped
// one item at a time, on the shared reciprocal divider; at most one char per cycle while out_stall is low
// error items present their single result in the cycle after acceptance
// synchronous active high reset returns the controller to idle
module number_to_roman_or_alpha_label_unit #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  nrl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output nrl_pkg::out_t out_data
);
  import nrl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  nrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // digit and character datapath
  nrl_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ----- tb/number_to_roman_or_alpha_label_unit_tb.sv -----
// self-checking testbench for the number to roman or alpha label unit
`timescale 1ns / 100ps

module number_to_roman_or_alpha_label_unit_tb;
  import nrl_pkg::*;

  localparam int RANDOM_LABELS = 410;
  localparam int QUIET_TAIL = 60;
  localparam int MAX_REPORTS = 10;

  // directed row: an empty typed text stands for the error label
  typedef struct {
    logic [1:0]  command;
    logic [15:0] value;
    bit          typed;
    string       text;
  } label_row_t;

  logic  clk;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  // characters still owed by the unit, oldest first
  out_t  expected_chars[$];
  out_t  want_char;
  int    mismatch_count = 0;
  int    chars_checked = 0;
  int    labels_sent = 0;
  int    error_labels = 0;
  bit    bursts_on = 1'b1;

  // predictor copy of the unit state
  logic [4:0] roman_groups[4];

  label_row_t directed_rows[] = '{
    '{STYLE_ALPHA_LOWER, 16'd0,     1'b1, ""},
    '{STYLE_ROMAN_UPPER, 16'd0,     1'b1, ""},
    '{STYLE_ALPHA_UPPER, 16'd0,     1'b1, ""},
    '{STYLE_ALPHA_LOWER, 16'd1,     1'b1, "a"},
    '{STYLE_ALPHA_UPPER, 16'd26,    1'b1, "Z"},
    '{STYLE_ALPHA_LOWER, 16'd27,    1'b1, "aa"},
    '{STYLE_ALPHA_UPPER, 16'd702,   1'b1, "ZZ"},
    '{STYLE_ALPHA_LOWER, 16'd703,   1'b1, "aaa"},
    '{STYLE_ALPHA_LOWER, 16'd65535, 1'b1, "crxo"},
    '{STYLE_ALPHA_UPPER, 16'd65535, 1'b1, "CRXO"},
    '{STYLE_ROMAN_LOWER, 16'd1,     1'b1, "i"},
    '{STYLE_ROMAN_UPPER, 16'd1000,  1'b1, "M"},
    '{STYLE_ROMAN_UPPER, 16'd3999,  1'b1, "MMMCMXCIX"},
    '{STYLE_ROMAN_LOWER, 16'd3888,  1'b1, "mmmdccclxxxviii"},
    '{STYLE_ROMAN_LOWER, 16'd4000,  1'b1, ""},
    '{STYLE_ROMAN_UPPER, 16'd65535, 1'b1, ""},
    '{STYLE_ROMAN_LOWER, 16'd4,     1'b0, ""},
    '{STYLE_ROMAN_UPPER, 16'd9,     1'b0, ""},
    '{STYLE_ROMAN_LOWER, 16'd1494,  1'b0, ""},
    '{STYLE_ROMAN_UPPER, 16'd949,   1'b0, ""},
    '{STYLE_ROMAN_LOWER, 16'd2730,  1'b0, ""},
    '{STYLE_ROMAN_UPPER, 16'd1365,  1'b0, ""},
    '{STYLE_ALPHA_LOWER, 16'h5555,  1'b0, ""},
    '{STYLE_ALPHA_UPPER, 16'hAAAA,  1'b0, ""},
    '{STYLE_ALPHA_LOWER, 16'h8000,  1'b0, ""}
  };

  number_to_roman_or_alpha_label_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // queue the characters of one label as the unit should emit them
  function automatic void predict_label(input in_t item);
    logic [7:0]  text[$];
    logic [7:0]  ones[1:3];
    logic [7:0]  fives[1:3];
    logic [7:0]  tens[1:3];
    logic [7:0]  ch;
    logic [15:0] x;
    logic [4:0]  d;
    bit          roman;
    bit          upper;
    roman = (item.command == STYLE_ROMAN_LOWER) || (item.command == STYLE_ROMAN_UPPER);
    upper = (item.command == STYLE_ALPHA_UPPER) || (item.command == STYLE_ROMAN_UPPER);
    ones = '{"c", "x", "i"};
    fives = '{"d", "l", "v"};
    tens = '{"m", "c", "x"};
    // zero, or a roman value past the top of the range
    if (item.value == 16'd0 || (roman && item.value > ROMAN_MAX)) begin
      expected_chars.push_back(out_t'{character: 7'd0, last: 1'b1, error: 1'b1});
      error_labels++;
      return;
    end
    if (!roman) begin
      // bijective base 26, least significant letter found first
      x = item.value;
      while (x != 16'd0) begin
        text.push_front(8'("a" + (x - 16'd1) % 16'd26));
        x = (x - 16'd1) / 16'd26;
      end
    end else begin
      roman_groups[0] = 5'(item.value / 16'd1000);
      roman_groups[1] = 5'((item.value / 16'd100) % 16'd10);
      roman_groups[2] = 5'((item.value / 16'd10) % 16'd10);
      roman_groups[3] = 5'(item.value % 16'd10);
      repeat (roman_groups[0]) text.push_back("m");
      for (int g = 1; g < 4; g++) begin
        d = roman_groups[g];
        case (d)
          5'd4: begin
            text.push_back(ones[g]);
            text.push_back(fives[g]);
          end
          5'd9: begin
            text.push_back(ones[g]);
            text.push_back(tens[g]);
          end
          default: begin
            if (d >= 5'd5) text.push_back(fives[g]);
            repeat (d % 5) text.push_back(ones[g]);
          end
        endcase
      end
    end
    foreach (text[k]) begin
      ch = upper ? text[k] - 8'd32 : text[k];
      expected_chars.push_back(out_t'{character: ch[6:0], last: k == text.size() - 1,
                                      error: 1'b0});
    end
  endfunction

  // expectation written out by hand, empty text meaning the error label
  function automatic void queue_typed(input string text);
    if (text.len() == 0) begin
      expected_chars.push_back(out_t'{character: 7'd0, last: 1'b1, error: 1'b1});
      error_labels++;
    end else begin
      for (int k = 0; k < text.len(); k++)
        expected_chars.push_back(out_t'{character: text[k][6:0], last: k == text.len() - 1,
                                        error: 1'b0});
    end
  endfunction

  function automatic in_t random_label();
    in_t item;
    int  pick;
    item.command = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 4)
      item.value = 16'd0;
    else if (item.command == STYLE_ROMAN_LOWER || item.command == STYLE_ROMAN_UPPER)
      item.value = (pick < 16) ? 16'($urandom_range(ROMAN_MAX + 1, 65535))
                               : 16'($urandom_range(1, ROMAN_MAX));
    else
      item.value = (pick < 50) ? 16'($urandom_range(1, 702))
                               : 16'($urandom_range(1, 65535));
    return item;
  endfunction

  // present one label request and hold it until the transfer
  task automatic send_label(input in_t item, input bit typed, input string text);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    if (typed) queue_typed(text);
    else predict_label(item);
    labels_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // occasional idle burst on the request side
  task automatic sender_gap();
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  function automatic void note_mismatch(input string what, input out_t want, input out_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected char %h last %b error %b, got char %h last %b error %b",
               $realtime, what, want.character, want.last, want.error,
               got.character, got.last, got.error);
  endfunction

  // random stall bursts on the result side
  initial begin
    forever begin
      @(negedge clk);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // check every output transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        note_mismatch("unexpected transfer", '0, out_data);
      end else begin
        want_char = expected_chars.pop_front();
        chars_checked++;
        if (out_data.character !== want_char.character || out_data.last !== want_char.last ||
            out_data.error !== want_char.error)
          note_mismatch("wrong character", want_char, out_data);
      end
    end
  end

  // stimulus and end of run
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_label(in_t'{command: directed_rows[i].command, value: directed_rows[i].value},
                 directed_rows[i].typed, directed_rows[i].text);
      sender_gap();
    end

    // hold off until the unit has emitted everything
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < RANDOM_LABELS; i++) begin
      bursts_on = (i < RANDOM_LABELS - QUIET_TAIL) && (i % 100 < 70);
      if (i == RANDOM_LABELS / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
      end
      send_label(random_label(), 1'b0, "");
      sender_gap();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);

    if (expected_chars.size() != 0) begin
      $display("%0d expected characters never arrived", expected_chars.size());
      mismatch_count += expected_chars.size();
    end
    $display("sent %0d labels in all four styles, %0d of them zero or out of range",
             labels_sent, error_labels);
    $display("checked %0d characters with random request gaps and output stalls",
             chars_checked);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // hard limit on run time
  initial begin
    #10_000_000;
    $display("timeout with %0d characters outstanding", expected_chars.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
